### hw/rtl/gn2d_pkg.sv
// ============================================================================
// gn2d_pkg
// Shared widths, command codes and limits for the 2-D gradient noise unit.
// ============================================================================
package gn2d_pkg;

   localparam int PERM_W  = 8;   // permutation entry and load index width
   localparam int GRAD_W  = 16;  // one gradient component, signed Q1.14
   localparam int COORD_W = 32;  // coordinate width
   localparam int NOISE_W = 16;  // result width, signed Q1.14
   localparam int DOT_W   = 18;  // corner dot product after rounding, signed Q14

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sd16384;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = -16'sd16384;

endpackage

### hw/rtl/gn2d_ram.sv
// ============================================================================
// gn2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module gn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

### hw/rtl/gn2d_fade.sv
// ============================================================================
// gn2d_fade
// Two-stage s-curve 3t^2 - 2t^3 on an unsigned fraction.
// ============================================================================
module gn2d_fade #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   fade_ff
);

   localparam int KW = FRAC_BITS + 2;
   localparam logic [KW-1:0] THREE_ONE = KW'(3) << FRAC_BITS;

   logic [FRAC_BITS-1:0]      t2_ff;
   logic [FRAC_BITS-1:0]      f_ff;
   logic [2*FRAC_BITS-1:0]    sq;
   logic [KW-1:0]             k;
   logic [FRAC_BITS+KW-1:0]   prod;
   logic [FRAC_BITS:0]        fade_in;

   assign sq      = frac * frac;
   assign k       = THREE_ONE - {1'b0, f_ff, 1'b0};
   assign prod    = {{KW{1'b0}}, t2_ff} * {{FRAC_BITS{1'b0}}, k};
   assign fade_in = prod[FRAC_BITS +: FRAC_BITS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff   <= sq[FRAC_BITS +: FRAC_BITS];
         f_ff    <= frac;
         fade_ff <= fade_in;
      end
   end

endmodule

### hw/rtl/gn2d_corner.sv
// ============================================================================
// gn2d_corner
// Two-stage corner dot product g . r, rounded half up to Q14.
// ============================================================================
module gn2d_corner #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [gn2d_pkg::GRAD_W-1:0]      grad_x,
   input  logic signed [gn2d_pkg::GRAD_W-1:0]      grad_y,
   input  logic signed [FRAC_BITS:0]               off_x,
   input  logic signed [FRAC_BITS:0]               off_y,
   output logic signed [gn2d_pkg::DOT_W-1:0]       dot_ff
);

   localparam int PW = gn2d_pkg::GRAD_W + FRAC_BITS + 1;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] HALF = SW'(longint'(1) << (FRAC_BITS - 1));

   logic signed [PW-1:0] px_ff;
   logic signed [PW-1:0] py_ff;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] shifted;

   assign sum     = SW'(px_ff) + SW'(py_ff) + HALF;
   assign shifted = sum >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= PW'(grad_x) * PW'(off_x);
         py_ff  <= PW'(grad_y) * PW'(off_y);
         dot_ff <= shifted[gn2d_pkg::DOT_W-1:0];
      end
   end

endmodule

### hw/rtl/gn2d_blend.sv
// ============================================================================
// gn2d_blend
// One-stage linear blend a + round(s * (b - a)) with s in [0, 1].
// ============================================================================
module gn2d_blend #(
   parameter int FRAC_BITS = 16,
   parameter int AW        = 18
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [FRAC_BITS:0]      weight,
   input  logic signed [AW-1:0]    val_a,
   input  logic signed [AW-1:0]    val_b,
   output logic signed [AW:0]      blend_ff
);

   localparam int PW = FRAC_BITS + AW + 3;
   localparam logic signed [PW-1:0] HALF = PW'(longint'(1) << (FRAC_BITS - 1));

   logic signed [AW:0]    diff;
   logic signed [PW-1:0]  prod;
   logic signed [PW-1:0]  shifted;
   logic signed [AW:0]    blend_in;

   assign diff     = (AW+1)'(val_b) - (AW+1)'(val_a);
   assign prod     = PW'($signed({1'b0, weight})) * PW'(diff) + HALF;
   assign shifted  = prod >>> FRAC_BITS;
   assign blend_in = (AW+1)'(val_a) + shifted[AW:0];

   always_ff @(posedge clock) begin
      if (en) begin
         blend_ff <= blend_in;
      end
   end

endmodule

### hw/rtl/gradient_noise_2d_unit.sv
// ============================================================================
// gradient_noise_2d_unit
// Pipelined two-dimensional gradient (Perlin) noise with loadable tables.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  command, table fields, point
//   rsp_      out        rsp_valid / rsp_stall  noise_value (signed Q1.14)
//
// Every evaluate beat passes seven register stages, the last being its result
// register, and a new beat may enter on every cycle that the pipeline is not
// held; the rate is one beat per cycle while no result waits under rsp_stall.
// The whole pipeline advances together; it holds only while a result waits
// under rsp_stall, and req_stall is raised in exactly those cycles.
// Reset clears the valid bits only. Table contents are undefined until loaded.
//
// A load beat writes each table copy at the stage where evaluate beats read
// that copy, so every beat sees the tables exactly as left by earlier beats.
// Stage 1 reads the permutation at the two x cells, stage 2 reads it at the
// four corners, stage 3 reads the four gradients, stages 4 and 5 form the dot
// products, stage 6 blends along x and stage 7 blends along y.
// ============================================================================
module gradient_noise_2d_unit #(
   parameter int TABLE_SIZE = 256,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_command,
   input  logic [7:0]                             req_table_index,
   input  logic [7:0]                             req_perm_entry,
   input  logic signed [15:0]                     req_grad_x,
   input  logic signed [15:0]                     req_grad_y,
   input  logic signed [31:0]                     req_coord_x,
   input  logic signed [31:0]                     req_coord_y,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [15:0]                     rsp_noise_value
);

   localparam int TW  = $clog2(TABLE_SIZE);
   localparam int PW  = gn2d_pkg::PERM_W;
   localparam int GW  = gn2d_pkg::GRAD_W;
   localparam int DW  = gn2d_pkg::DOT_W;
   localparam int EXT = gn2d_pkg::COORD_W + TW;

   // Reduce an 8-bit index or permutation value modulo the table size.
   function automatic logic [TW-1:0] to_idx(input logic [PW-1:0] v);
      logic [PW+TW-1:0] t;
      t = {{TW{1'b0}}, v};
      return t[TW-1:0];
   endfunction

   logic en;
   logic req_take;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign req_take  = req_valid && en;

   // ---------------------------------------------------------------- stage 1
   logic signed [EXT-1:0] ext_x;
   logic signed [EXT-1:0] ext_y;
   logic [TW-1:0]         cx0;
   logic [TW-1:0]         cx1;
   logic                  load_req;

   assign ext_x    = EXT'(req_coord_x);
   assign ext_y    = EXT'(req_coord_y);
   assign cx0      = ext_x[FRAC_BITS +: TW];
   assign cx1      = TW'(cx0 + TW'(1));
   assign load_req = req_take && (req_command == gn2d_pkg::CMD_LOAD);

   logic                  load1_ff, eval1_ff;
   logic [TW-1:0]         idx1_ff;
   logic [PW-1:0]         perm1_ff;
   logic [2*GW-1:0]       grad1_ff;
   logic [TW-1:0]         cy1_ff;
   logic [FRAC_BITS-1:0]  fx1_ff, fy1_ff;

   logic [PW-1:0] perm_i, perm_j;

   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_i (
      .clock(clock), .we(load_req), .waddr(to_idx(req_table_index)),
      .wdata(req_perm_entry), .re(en), .raddr(cx0), .rdata(perm_i)
   );

   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_j (
      .clock(clock), .we(load_req), .waddr(to_idx(req_table_index)),
      .wdata(req_perm_entry), .re(en), .raddr(cx1), .rdata(perm_j)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         load1_ff <= 1'b0;
         eval1_ff <= 1'b0;
      end else if (en) begin
         load1_ff <= req_valid && (req_command == gn2d_pkg::CMD_LOAD);
         eval1_ff <= req_valid && (req_command == gn2d_pkg::CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx1_ff  <= to_idx(req_table_index);
         perm1_ff <= req_perm_entry;
         grad1_ff <= {req_grad_y, req_grad_x};
         cy1_ff   <= ext_y[FRAC_BITS +: TW];
         fx1_ff   <= req_coord_x[FRAC_BITS-1:0];
         fy1_ff   <= req_coord_y[FRAC_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic [TW-1:0] a00, a10, a01, a11;
   logic          load1_we;

   assign a00      = TW'(to_idx(perm_i) + cy1_ff);
   assign a10      = TW'(to_idx(perm_j) + cy1_ff);
   assign a01      = TW'(a00 + TW'(1));
   assign a11      = TW'(a10 + TW'(1));
   assign load1_we = load1_ff && en;

   logic [PW-1:0] b00, b10, b01, b11;

   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_00 (
      .clock(clock), .we(load1_we), .waddr(idx1_ff), .wdata(perm1_ff),
      .re(en), .raddr(a00), .rdata(b00)
   );
   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_10 (
      .clock(clock), .we(load1_we), .waddr(idx1_ff), .wdata(perm1_ff),
      .re(en), .raddr(a10), .rdata(b10)
   );
   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_01 (
      .clock(clock), .we(load1_we), .waddr(idx1_ff), .wdata(perm1_ff),
      .re(en), .raddr(a01), .rdata(b01)
   );
   gn2d_ram #(.WIDTH(PW), .DEPTH(TABLE_SIZE)) u_perm_11 (
      .clock(clock), .we(load1_we), .waddr(idx1_ff), .wdata(perm1_ff),
      .re(en), .raddr(a11), .rdata(b11)
   );

   // The s-curve weights are registered inside each fade unit and land in stage 3.
   logic [FRAC_BITS:0] sx3, sy3;

   gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock(clock), .en(en), .frac(fx1_ff), .fade_ff(sx3)
   );
   gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock(clock), .en(en), .frac(fy1_ff), .fade_ff(sy3)
   );

   logic                 load2_ff, eval2_ff;
   logic [TW-1:0]        idx2_ff;
   logic [2*GW-1:0]      grad2_ff;
   logic [FRAC_BITS-1:0] fx2_ff, fy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load2_ff <= 1'b0;
         eval2_ff <= 1'b0;
      end else if (en) begin
         load2_ff <= load1_ff;
         eval2_ff <= eval1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx2_ff  <= idx1_ff;
         grad2_ff <= grad1_ff;
         fx2_ff   <= fx1_ff;
         fy2_ff   <= fy1_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic            load2_we;
   logic [2*GW-1:0] g00, g10, g01, g11;

   assign load2_we = load2_ff && en;

   gn2d_ram #(.WIDTH(2*GW), .DEPTH(TABLE_SIZE)) u_grad_00 (
      .clock(clock), .we(load2_we), .waddr(idx2_ff), .wdata(grad2_ff),
      .re(en), .raddr(to_idx(b00)), .rdata(g00)
   );
   gn2d_ram #(.WIDTH(2*GW), .DEPTH(TABLE_SIZE)) u_grad_10 (
      .clock(clock), .we(load2_we), .waddr(idx2_ff), .wdata(grad2_ff),
      .re(en), .raddr(to_idx(b10)), .rdata(g10)
   );
   gn2d_ram #(.WIDTH(2*GW), .DEPTH(TABLE_SIZE)) u_grad_01 (
      .clock(clock), .we(load2_we), .waddr(idx2_ff), .wdata(grad2_ff),
      .re(en), .raddr(to_idx(b01)), .rdata(g01)
   );
   gn2d_ram #(.WIDTH(2*GW), .DEPTH(TABLE_SIZE)) u_grad_11 (
      .clock(clock), .we(load2_we), .waddr(idx2_ff), .wdata(grad2_ff),
      .re(en), .raddr(to_idx(b11)), .rdata(g11)
   );

   logic                 eval3_ff;
   logic [FRAC_BITS-1:0] fx3_ff, fy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval3_ff <= 1'b0;
      end else if (en) begin
         eval3_ff <= eval2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fx3_ff <= fx2_ff;
         fy3_ff <= fy2_ff;
      end
   end

   // ------------------------------------------------------- stages 4 and 5
   // Offsets from the near corner are the fraction; from the far corner the
   // fraction minus one, which is the same bits under a set sign bit.
   logic signed [FRAC_BITS:0] rx0, rx1, ry0, ry1;

   assign rx0 = $signed({1'b0, fx3_ff});
   assign rx1 = $signed({1'b1, fx3_ff});
   assign ry0 = $signed({1'b0, fy3_ff});
   assign ry1 = $signed({1'b1, fy3_ff});

   logic signed [DW-1:0] d00, d10, d01, d11;

   gn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_dot_00 (
      .clock(clock), .en(en), .grad_x($signed(g00[GW-1:0])),
      .grad_y($signed(g00[2*GW-1:GW])), .off_x(rx0), .off_y(ry0), .dot_ff(d00)
   );
   gn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_dot_10 (
      .clock(clock), .en(en), .grad_x($signed(g10[GW-1:0])),
      .grad_y($signed(g10[2*GW-1:GW])), .off_x(rx1), .off_y(ry0), .dot_ff(d10)
   );
   gn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_dot_01 (
      .clock(clock), .en(en), .grad_x($signed(g01[GW-1:0])),
      .grad_y($signed(g01[2*GW-1:GW])), .off_x(rx0), .off_y(ry1), .dot_ff(d01)
   );
   gn2d_corner #(.FRAC_BITS(FRAC_BITS)) u_dot_11 (
      .clock(clock), .en(en), .grad_x($signed(g11[GW-1:0])),
      .grad_y($signed(g11[2*GW-1:GW])), .off_x(rx1), .off_y(ry1), .dot_ff(d11)
   );

   logic                 eval4_ff, eval5_ff, eval6_ff;
   logic [FRAC_BITS:0]   sx4_ff, sy4_ff, sx5_ff, sy5_ff, sy6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval4_ff <= 1'b0;
         eval5_ff <= 1'b0;
         eval6_ff <= 1'b0;
      end else if (en) begin
         eval4_ff <= eval3_ff;
         eval5_ff <= eval4_ff;
         eval6_ff <= eval5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx4_ff <= sx3;
         sy4_ff <= sy3;
         sx5_ff <= sx4_ff;
         sy5_ff <= sy4_ff;
         sy6_ff <= sy5_ff;
      end
   end

   // ------------------------------------------------------- stages 6 and 7
   logic signed [DW:0]   lerp_lo, lerp_hi;
   logic signed [DW+1:0] lerp_out;

   gn2d_blend #(.FRAC_BITS(FRAC_BITS), .AW(DW)) u_blend_lo (
      .clock(clock), .en(en), .weight(sx5_ff), .val_a(d00), .val_b(d10),
      .blend_ff(lerp_lo)
   );
   gn2d_blend #(.FRAC_BITS(FRAC_BITS), .AW(DW)) u_blend_hi (
      .clock(clock), .en(en), .weight(sx5_ff), .val_a(d01), .val_b(d11),
      .blend_ff(lerp_hi)
   );
   gn2d_blend #(.FRAC_BITS(FRAC_BITS), .AW(DW+1)) u_blend_y (
      .clock(clock), .en(en), .weight(sy6_ff), .val_a(lerp_lo), .val_b(lerp_hi),
      .blend_ff(lerp_out)
   );

   logic eval7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eval7_ff <= 1'b0;
      end else if (en) begin
         eval7_ff <= eval6_ff;
      end
   end

   // Clamp the blended sample to the Q1.14 range of plus and minus one.
   assign rsp_valid = eval7_ff;

   always_comb begin
      if (lerp_out > (DW+2)'(gn2d_pkg::NOISE_MAX)) begin
         rsp_noise_value = gn2d_pkg::NOISE_MAX;
      end else if (lerp_out < (DW+2)'(gn2d_pkg::NOISE_MIN)) begin
         rsp_noise_value = gn2d_pkg::NOISE_MIN;
      end else begin
         rsp_noise_value = lerp_out[gn2d_pkg::NOISE_W-1:0];
      end
   end

endmodule

### tb/gn2d_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// gn2d_checker
// Watches both channels of the gradient noise unit, predicts every noise
// sample from its own copy of the tables and compares it with the result.
// ============================================================================
module gn2d_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_command,
   input  logic [gn2d_pkg::PERM_W-1:0]         req_table_index,
   input  logic [gn2d_pkg::PERM_W-1:0]         req_perm_entry,
   input  logic signed [gn2d_pkg::GRAD_W-1:0]  req_grad_x,
   input  logic signed [gn2d_pkg::GRAD_W-1:0]  req_grad_y,
   input  logic signed [gn2d_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [gn2d_pkg::COORD_W-1:0] req_coord_y,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [gn2d_pkg::NOISE_W-1:0] rsp_noise_value,
   output int                                  pending,
   output int                                  fail_count
);

   logic [gn2d_pkg::PERM_W-1:0]         perm_mem [256];
   logic signed [gn2d_pkg::GRAD_W-1:0]  gx_mem   [256];
   logic signed [gn2d_pkg::GRAD_W-1:0]  gy_mem   [256];
   logic signed [gn2d_pkg::NOISE_W-1:0] noise_expected [$];

   function automatic longint rnd_shift16(longint v);
      return (v + 64'sd32768) >>> 16;
   endfunction

   function automatic longint s_curve(longint t);
      longint t2;
      t2 = (t * t) >>> 16;
      return (t2 * (3 * 65536 - 2 * t)) >>> 16;
   endfunction

   function automatic longint corner_dot(int idx, longint rx, longint ry);
      longint gx, gy;
      gx = gx_mem[idx];
      gy = gy_mem[idx];
      return rnd_shift16(gx * rx + gy * ry);
   endfunction

   function automatic longint mix(longint s, longint a, longint b);
      return a + rnd_shift16(s * (b - a));
   endfunction

   function automatic logic signed [gn2d_pkg::NOISE_W-1:0] noise_at(
         logic signed [31:0] cx, logic signed [31:0] cy);
      longint px, py, fx, fy, sx, sy, u, v, a, b, r;
      int c0x, c1x, c0y, c1y, i, j;
      px  = cx;
      py  = cy;
      c0x = int'((px >>> 16) & 255);
      c0y = int'((py >>> 16) & 255);
      c1x = (c0x + 1) & 255;
      c1y = (c0y + 1) & 255;
      fx  = px & 65535;
      fy  = py & 65535;
      i   = perm_mem[c0x];
      j   = perm_mem[c1x];
      sx  = s_curve(fx);
      sy  = s_curve(fy);
      u = corner_dot(perm_mem[(i + c0y) & 255], fx, fy);
      v = corner_dot(perm_mem[(j + c0y) & 255], fx - 65536, fy);
      a = mix(sx, u, v);
      u = corner_dot(perm_mem[(i + c1y) & 255], fx, fy - 65536);
      v = corner_dot(perm_mem[(j + c1y) & 255], fx - 65536, fy - 65536);
      b = mix(sx, u, v);
      r = mix(sy, a, b);
      if (r > gn2d_pkg::NOISE_MAX) r = gn2d_pkg::NOISE_MAX;
      if (r < gn2d_pkg::NOISE_MIN) r = gn2d_pkg::NOISE_MIN;
      return r[gn2d_pkg::NOISE_W-1:0];
   endfunction

   initial begin
      pending    = 0;
      fail_count = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (noise_expected.size() == 0) begin
               $error("unexpected result beat, noise_value %0d", rsp_noise_value);
               fail_count = fail_count + 1;
            end else begin
               if (rsp_noise_value !== noise_expected[0]) begin
                  $error("noise_value expected %0d actual %0d",
                         noise_expected[0], rsp_noise_value);
                  fail_count = fail_count + 1;
               end
               void'(noise_expected.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == gn2d_pkg::CMD_LOAD) begin
               perm_mem[req_table_index] = req_perm_entry;
               gx_mem[req_table_index]   = req_grad_x;
               gy_mem[req_table_index]   = req_grad_y;
            end else begin
               noise_expected.push_back(noise_at(req_coord_x, req_coord_y));
            end
         end
         pending = noise_expected.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Stimulus and verdict for the 2-D gradient noise unit.
// ============================================================================
// The tables are filled completely before the first evaluation, so no beat ever
// reads an entry that was never loaded. A short directed part then covers the
// extreme points and gradients, after which mixed load and evaluate beats run
// in three idling phases. The checker beside the block does all prediction.
// ============================================================================
module tb;

   localparam int RANDOM_BEATS = 1750;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_command;
   logic [gn2d_pkg::PERM_W-1:0]         req_table_index;
   logic [gn2d_pkg::PERM_W-1:0]         req_perm_entry;
   logic signed [gn2d_pkg::GRAD_W-1:0]  req_grad_x;
   logic signed [gn2d_pkg::GRAD_W-1:0]  req_grad_y;
   logic signed [gn2d_pkg::COORD_W-1:0] req_coord_x;
   logic signed [gn2d_pkg::COORD_W-1:0] req_coord_y;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic signed [gn2d_pkg::NOISE_W-1:0] rsp_noise_value;

   int pending;
   int fail_count;
   int cycles;

   // Idle rates in percent for the two sides; the phases change them.
   int send_idle_pct;
   int recv_idle_pct;

   // A long receiver hold-off is requested once; the receiver counts it out.
   logic hold_go;
   logic hold_done;
   int   hold_left;

   gradient_noise_2d_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_table_index (req_table_index),
      .req_perm_entry  (req_perm_entry),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value)
   );

   gn2d_checker noise_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_table_index (req_table_index),
      .req_perm_entry  (req_perm_entry),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_noise_value (rsp_noise_value),
      .pending         (pending),
      .fail_count      (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut off if it ever takes far longer than the slowest correct run.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // The receiver stalls at random at the current rate, except during the one
   // long hold-off, when it keeps stall high so the pipeline fills up and the
   // block has to stall its input.
   initial begin
      hold_done = 1'b0;
      hold_left = 0;
   end
   always @(negedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offers one beat and returns after the rising edge that accepts it. The
   // valid stays high between back-to-back beats, so it is only ever written
   // once per falling edge. Each cycle the sender idles at the current rate.
   task automatic send_beat(logic cmd, logic [7:0] idx, logic [7:0] perm,
                            logic [15:0] gx, logic [15:0] gy,
                            logic [31:0] px, logic [31:0] py);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_command     = cmd;
      req_table_index = idx;
      req_perm_entry  = perm;
      req_grad_x      = gx;
      req_grad_y      = gy;
      req_coord_x     = px;
      req_coord_y     = py;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly gradient components within plus and minus one; now and then any 16-bit
   // value, which can drive the result into saturation.
   function automatic logic [15:0] pick_grad();
      case ($urandom_range(9))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2, 3: return 16'($urandom());
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   // Coordinates are either anywhere in the full range or near the origin, so
   // that the lattice wraps and the fractions are both exercised.
   function automatic logic [31:0] pick_coord();
      if ($urandom_range(1)) return $urandom();
      return $urandom_range(32'h0040_0000) - 32'h0020_0000;
   endfunction

   task automatic random_beats(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 15)
            send_beat(gn2d_pkg::CMD_LOAD, 8'($urandom()), 8'($urandom()),
                      pick_grad(), pick_grad(), $urandom(), $urandom());
         else
            send_beat(gn2d_pkg::CMD_EVAL, 8'($urandom()), 8'($urandom()),
                      16'($urandom()), 16'($urandom()), pick_coord(), pick_coord());
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = gn2d_pkg::CMD_LOAD;
      req_table_index = '0;
      req_perm_entry  = '0;
      req_grad_x      = '0;
      req_grad_y      = '0;
      req_coord_x     = '0;
      req_coord_y     = '0;
      rsp_stall       = 1'b0;
      hold_go         = 1'b0;
      send_idle_pct   = 37;
      recv_idle_pct   = 88;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Every table entry is loaded before anything is evaluated.
      for (int k = 0; k < 256; k++)
         send_beat(gn2d_pkg::CMD_LOAD, 8'(k), 8'($urandom()), pick_grad(), pick_grad(),
                   '0, '0);

      // Directed points: origin, the extreme coordinates, a fraction of one
      // half, and cells on either side of the wrap of the lattice.
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_0000, 32'h0000_0000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h8000_0000, 32'h8000_0000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h7fff_ffff, 32'h8000_0000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'hffff_ffff, 32'h0000_0001);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_8000, 32'h0000_8000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h00ff_ffff, 32'h0100_0000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'hffff_0000, 32'h0000_ffff);

      // Oversized gradients on a whole cell so that the sample saturates both ways.
      for (int k = 0; k < 256; k += 51)
         send_beat(gn2d_pkg::CMD_LOAD, 8'(k), 8'hff, 16'sh7fff, 16'sh7fff, '0, '0);
      send_beat(gn2d_pkg::CMD_LOAD, 8'hff, 8'h00, 16'sh8000, 16'sh8000, '0, '0);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0000_8000, 32'h0000_8000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h0033_c000, 32'h00ff_4000);
      send_beat(gn2d_pkg::CMD_EVAL, '0, '0, '0, '0, 32'h00ff_8000, 32'h00ff_8000);

      // The sender holds back here until every expected result has come.
      wait_drained();

      random_beats(RANDOM_BEATS / 3);
      wait_drained();

      send_idle_pct = 88;
      recv_idle_pct = 37;
      random_beats(RANDOM_BEATS / 3);
      wait_drained();

      // No idling; the long hold-off starts shortly into this phase while the
      // sender keeps offering beats.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_beats(50);
      hold_go = 1'b1;
      random_beats(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3) - 50);
      wait_drained();

      // Let the pipeline run out so a stray late result would still be seen.
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
